### rtl/core/rv32x_pkg.sv
package rv32x_pkg;

    // Architectural sizes
    localparam int unsigned XLEN          = 32;
    localparam int unsigned REG_COUNT     = 32;
    localparam int unsigned REG_IDX_W     = 5;
    localparam int unsigned MEM_BYTES_DEF = 4096;
    localparam int unsigned MEM_ADDR_W    = 12;
    localparam int unsigned BANKS         = 4;

    // Item command codes
    typedef enum logic [1:0] {
        CMD_EXEC    = 2'd0,
        CMD_PRELOAD = 2'd1,
        CMD_SET_PC  = 2'd2
    } t_cmd;

    // Instruction codes
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_LW   = 4'd2,
        OP_LH   = 4'd3,
        OP_LHU  = 4'd4,
        OP_LB   = 4'd5,
        OP_LBU  = 4'd6,
        OP_SW   = 4'd7,
        OP_SH   = 4'd8,
        OP_SB   = 4'd9,
        OP_BEQ  = 4'd10,
        OP_BNE  = 4'd11,
        OP_BLT  = 4'd12,
        OP_BGE  = 4'd13,
        OP_BLTU = 4'd14,
        OP_BGEU = 4'd15
    } t_op;

    // Input item
    typedef struct packed {
        logic [1:0]           cmd;
        logic [3:0]           op;
        logic [REG_IDX_W-1:0] dest_reg;
        logic [REG_IDX_W-1:0] src_a;
        logic [REG_IDX_W-1:0] src_b;
        logic signed [11:0]   imm;
        logic [XLEN-1:0]      branch_target;
        logic [XLEN-1:0]      address;
        logic [7:0]           preload_byte;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [XLEN-1:0]        next_pc;
        logic                   reg_written;
        logic [REG_IDX_W-1:0]   reg_index;
        logic signed [XLEN-1:0] reg_value;
        logic                   zero_blocked;
        logic                   branch_taken;
        logic                   mem_written;
        logic [MEM_ADDR_W-1:0]  mem_address;
        logic signed [XLEN-1:0] mem_value;
    } t_out_item;

endpackage

### rtl/core/rv32x_ram.sv
module rv32x_ram #(
    parameter int unsigned WIDTH = rv32x_pkg::XLEN,
    parameter int unsigned DEPTH = rv32x_pkg::REG_COUNT
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port (read returns the old contents)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/rv32_subset_execute_unit_core.sv
// Execute stage for a small RV32I subset (add, sub, loads, stores, compare branches) with its own
// 32-entry register file, byte-addressed big-endian data memory of MEM_BYTES bytes (a power of
// two, at least 16; addresses wrap per byte) and PC. It takes one item per cycle unless stalled:
// the accepting edge reads the register file, the edge that moves the item into stage two reads
// the four byte-lane memory banks, and the edge that moves it out of stage two writes back and
// loads the output register.
// Back-to-back dependencies through registers and memory are forwarded, so the rate stays at one
// item per cycle whatever the instruction mix; only a stall on the output side or the clearing
// sweep slows it. After reset the block sweeps the data memory to zero, row by row across the
// banks, with the input stalled until the sweep finishes.
module rv32_subset_execute_unit_core #(
    parameter int unsigned MEM_BYTES = rv32x_pkg::MEM_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  rv32x_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output rv32x_pkg::t_out_item o_out_item
);

    localparam int unsigned XLEN  = rv32x_pkg::XLEN;
    localparam int unsigned RIW   = rv32x_pkg::REG_IDX_W;
    localparam int unsigned NREG  = rv32x_pkg::REG_COUNT;
    localparam int unsigned BANKS = rv32x_pkg::BANKS;
    localparam int unsigned LW    = $clog2(BANKS);
    localparam int unsigned AW    = $clog2(MEM_BYTES);
    localparam int unsigned ROWS  = MEM_BYTES / BANKS;
    localparam int unsigned RW    = AW - LW;

    // Stage-two item: operands resolved, memory address wrapped
    typedef struct packed {
        logic [1:0]      cmd;
        logic [3:0]      op;
        logic [RIW-1:0]  rd;
        logic [XLEN-1:0] alu;
        logic            cond;
        logic [XLEN-1:0] sdata;
        logic [2:0]      cnt;
        logic [AW-1:0]   ma;
        logic [XLEN-1:0] target;
        logic [XLEN-1:0] address;
    } t_s2;

    // Pipeline registers
    logic                 r_s1_v;
    logic                 r_s2_v;
    logic                 r_out_v;
    rv32x_pkg::t_in_item  r_s1;
    t_s2                  r_s2;
    t_s2                  n_s2;
    rv32x_pkg::t_out_item r_out;
    rv32x_pkg::t_out_item n_out;
    logic [XLEN-1:0]      r_pc;
    logic [XLEN-1:0]      n_pc;

    // Register file bookkeeping and write-back bypass
    logic [NREG-1:0]      r_rf_vld;
    logic                 r_wb_v;
    logic [RIW-1:0]       r_wb_idx;
    logic [XLEN-1:0]      r_wb_val;

    // Last write seen by each memory bank
    logic [BANKS-1:0]     r_mfw_v;
    logic [RW-1:0]        r_mfw_row  [BANKS];
    logic [7:0]           r_mfw_data [BANKS];

    // Memory clearing sweep
    logic                 r_clr_busy;
    logic [RW-1:0]        r_clr_row;

    // Handshake
    logic                 w_s2_adv;
    logic                 w_s2_free;
    logic                 w_s1_adv;
    logic                 w_s1_free;
    logic                 w_in_acc;

    // Stage-one operands
    logic [XLEN-1:0]      w_rf_rdata [2];
    logic [RIW-1:0]       w_src_idx  [2];
    logic [XLEN-1:0]      w_src_val  [2];
    logic [XLEN-1:0]      w_va;
    logic [XLEN-1:0]      w_vb;
    logic [XLEN-1:0]      w_imm_ext;
    logic [XLEN-1:0]      w_ea;
    logic [AW-1:0]        w_s1_ma;
    logic [RW-1:0]        w_bank_raddr [BANKS];

    // Stage-two datapath
    logic [LW-1:0]        w_lo;
    logic [RW-1:0]        w_row_base;
    logic [RW-1:0]        w_row   [BANKS];
    logic [7:0]           w_bank_rdata [BANKS];
    logic [7:0]           w_lane  [BANKS];
    logic [7:0]           w_byte  [BANKS];
    logic [XLEN-1:0]      w_ld_word;
    logic [XLEN-1:0]      w_s2_result;
    logic                 w_s2_rwr_op;
    logic                 w_s2_rf_we;
    logic                 w_s2_store;
    logic                 w_s2_mem_wr;
    logic                 w_s2_taken;
    logic [BANKS-1:0]     w_lane_we;
    logic [7:0]           w_lane_wdata [BANKS];
    logic [BANKS-1:0]     w_bank_we;
    logic [RW-1:0]        w_bank_waddr [BANKS];
    logic [7:0]           w_bank_wdata [BANKS];
    logic [31:0]          w_ma_ext;

    // Elastic pipeline control: each stage moves when the next one frees up
    assign w_s2_adv   = r_s2_v & (~r_out_v | ~i_out_stall);
    assign w_s2_free  = ~r_s2_v | w_s2_adv;
    assign w_s1_adv   = r_s1_v & w_s2_free;
    assign w_s1_free  = ~r_s1_v | w_s1_adv;
    assign o_in_stall = r_clr_busy | ~w_s1_free;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    // Register file: two copies give two read ports
    rv32x_ram #(
        .WIDTH (XLEN),
        .DEPTH (NREG)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (w_s2_adv & w_s2_rf_we),
        .i_waddr (r_s2.rd),
        .i_wdata (w_s2_result),
        .i_re    (w_in_acc),
        .i_raddr (i_in_item.src_a),
        .o_rdata (w_rf_rdata[0])
    );

    rv32x_ram #(
        .WIDTH (XLEN),
        .DEPTH (NREG)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (w_s2_adv & w_s2_rf_we),
        .i_waddr (r_s2.rd),
        .i_wdata (w_s2_result),
        .i_re    (w_in_acc),
        .i_raddr (i_in_item.src_b),
        .o_rdata (w_rf_rdata[1])
    );

    // Resolve operands: stage-two result, then last write-back, then the RAM
    assign w_src_idx[0] = r_s1.src_a;
    assign w_src_idx[1] = r_s1.src_b;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            if (w_src_idx[s] == '0) begin
                w_src_val[s] = '0;
            end else if (r_s2_v && w_s2_rf_we && r_s2.rd == w_src_idx[s]) begin
                w_src_val[s] = w_s2_result;
            end else if (r_wb_v && r_wb_idx == w_src_idx[s]) begin
                w_src_val[s] = r_wb_val;
            end else if (r_rf_vld[w_src_idx[s]]) begin
                w_src_val[s] = w_rf_rdata[s];
            end else begin
                w_src_val[s] = '0;
            end
        end
    end

    assign w_va      = w_src_val[0];
    assign w_vb      = w_src_val[1];
    assign w_imm_ext = {{(XLEN - 12){r_s1.imm[11]}}, r_s1.imm};

    // Stage one: address, ALU, branch compare, store data
    always_comb begin
        if (r_s1.op inside {rv32x_pkg::OP_SW, rv32x_pkg::OP_SH, rv32x_pkg::OP_SB}) begin
            w_ea = w_vb + w_imm_ext;
        end else begin
            w_ea = w_va + w_imm_ext;
        end

        if (r_s1.cmd == rv32x_pkg::CMD_PRELOAD) begin
            w_s1_ma = r_s1.address[AW-1:0];
        end else begin
            w_s1_ma = w_ea[AW-1:0];
        end

        n_s2.cmd     = r_s1.cmd;
        n_s2.op      = r_s1.op;
        n_s2.rd      = r_s1.dest_reg;
        n_s2.ma      = w_s1_ma;
        n_s2.target  = r_s1.branch_target;
        n_s2.address = r_s1.address;

        if (r_s1.op == rv32x_pkg::OP_SUB) begin
            n_s2.alu = w_va - w_vb;
        end else begin
            n_s2.alu = w_va + w_vb;
        end

        case (r_s1.op)
            rv32x_pkg::OP_BEQ:  n_s2.cond = (w_va == w_vb);
            rv32x_pkg::OP_BNE:  n_s2.cond = (w_va != w_vb);
            rv32x_pkg::OP_BLT:  n_s2.cond = ($signed(w_va) < $signed(w_vb));
            rv32x_pkg::OP_BGE:  n_s2.cond = ($signed(w_va) >= $signed(w_vb));
            rv32x_pkg::OP_BLTU: n_s2.cond = (w_va < w_vb);
            rv32x_pkg::OP_BGEU: n_s2.cond = (w_va >= w_vb);
            default:            n_s2.cond = 1'b0;
        endcase

        if (r_s1.cmd == rv32x_pkg::CMD_PRELOAD) begin
            n_s2.cnt   = 3'd1;
            n_s2.sdata = {{(XLEN - 8){1'b0}}, r_s1.preload_byte};
        end else begin
            case (r_s1.op)
                rv32x_pkg::OP_SW: begin
                    n_s2.cnt   = 3'd4;
                    n_s2.sdata = w_va;
                end
                rv32x_pkg::OP_SH: begin
                    n_s2.cnt   = 3'd2;
                    n_s2.sdata = {{(XLEN - 16){1'b0}}, w_va[15:0]};
                end
                default: begin
                    n_s2.cnt   = 3'd1;
                    n_s2.sdata = {{(XLEN - 8){1'b0}}, w_va[7:0]};
                end
            endcase
        end

        // Lanes below the start offset belong to the next row
        for (int b = 0; b < BANKS; b++) begin
            w_bank_raddr[b] = w_s1_ma[AW-1:LW] + RW'(LW'(b) < w_s1_ma[LW-1:0]);
        end
    end

    // Data memory: one bank per byte lane
    for (genvar g = 0; g < BANKS; g++) begin : g_bank
        rv32x_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_bank_we[g]),
            .i_waddr (w_bank_waddr[g]),
            .i_wdata (w_bank_wdata[g]),
            .i_re    (w_s1_adv),
            .i_raddr (w_bank_raddr[g]),
            .o_rdata (w_bank_rdata[g])
        );
    end

    // Stage two: merge the bank bypass, assemble loads, plan stores
    assign w_lo       = r_s2.ma[LW-1:0];
    assign w_row_base = r_s2.ma[AW-1:LW];

    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            w_row[b] = w_row_base + RW'(LW'(b) < w_lo);
            if (r_mfw_v[b] && r_mfw_row[b] == w_row[b]) begin
                w_lane[b] = r_mfw_data[b];
            end else begin
                w_lane[b] = w_bank_rdata[b];
            end
        end
        // Byte k of the access sits in lane (start + k); lowest address is most significant
        for (int k = 0; k < BANKS; k++) begin
            w_byte[k] = w_lane[LW'(w_lo + LW'(k))];
        end
    end

    assign w_ld_word = {w_byte[0], w_byte[1], w_byte[2], w_byte[3]};

    always_comb begin
        case (r_s2.op)
            rv32x_pkg::OP_LW:  w_s2_result = w_ld_word;
            rv32x_pkg::OP_LH:  w_s2_result = {{16{w_byte[0][7]}}, w_byte[0], w_byte[1]};
            rv32x_pkg::OP_LHU: w_s2_result = {16'h0000, w_byte[0], w_byte[1]};
            rv32x_pkg::OP_LB:  w_s2_result = {{24{w_byte[0][7]}}, w_byte[0]};
            rv32x_pkg::OP_LBU: w_s2_result = {24'h000000, w_byte[0]};
            default:           w_s2_result = r_s2.alu;
        endcase
    end

    assign w_s2_rwr_op = (r_s2.cmd == rv32x_pkg::CMD_EXEC) &&
                         (r_s2.op inside {[rv32x_pkg::OP_ADD:rv32x_pkg::OP_LBU]});
    assign w_s2_rf_we  = w_s2_rwr_op && (r_s2.rd != '0);
    assign w_s2_store  = (r_s2.cmd == rv32x_pkg::CMD_EXEC) &&
                         (r_s2.op inside {[rv32x_pkg::OP_SW:rv32x_pkg::OP_SB]});
    assign w_s2_mem_wr = w_s2_store || (r_s2.cmd == rv32x_pkg::CMD_PRELOAD);
    assign w_s2_taken  = (r_s2.cmd == rv32x_pkg::CMD_EXEC) &&
                         (r_s2.op inside {[rv32x_pkg::OP_BEQ:rv32x_pkg::OP_BGEU]}) && r_s2.cond;

    // Store lanes: lane b carries byte (b - start) of the value, if inside the width
    always_comb begin
        logic [LW-1:0] k;
        logic [LW-1:0] top;
        logic [LW-1:0] sh;
        for (int b = 0; b < BANKS; b++) begin
            k               = LW'(LW'(b) - w_lo);
            top             = LW'(r_s2.cnt - 3'd1);
            sh              = LW'(top - k);
            w_lane_we[b]    = w_s2_mem_wr && (3'(k) < r_s2.cnt);
            w_lane_wdata[b] = 8'(r_s2.sdata >> {sh, 3'b000});
        end
    end

    // Bank write ports: the clearing sweep owns them until it finishes
    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            if (r_clr_busy) begin
                w_bank_we[b]    = 1'b1;
                w_bank_waddr[b] = r_clr_row;
                w_bank_wdata[b] = '0;
            end else begin
                w_bank_we[b]    = w_s2_adv & w_lane_we[b];
                w_bank_waddr[b] = w_row[b];
                w_bank_wdata[b] = w_lane_wdata[b];
            end
        end
    end

    // Next PC and result item
    assign w_ma_ext = 32'(r_s2.ma);

    always_comb begin
        n_pc = r_pc;
        if (r_s2.cmd == rv32x_pkg::CMD_SET_PC) begin
            n_pc = r_s2.address;
        end else if (r_s2.cmd == rv32x_pkg::CMD_EXEC) begin
            n_pc = w_s2_taken ? r_s2.target : r_pc + 32'd4;
        end

        n_out.next_pc      = n_pc;
        n_out.reg_written  = w_s2_rf_we;
        n_out.reg_index    = w_s2_rf_we ? r_s2.rd : '0;
        n_out.reg_value    = w_s2_rf_we ? w_s2_result : '0;
        n_out.zero_blocked = w_s2_rwr_op && (r_s2.rd == '0);
        n_out.branch_taken = w_s2_taken;
        n_out.mem_written  = w_s2_mem_wr;
        n_out.mem_address  = w_s2_mem_wr ? w_ma_ext[rv32x_pkg::MEM_ADDR_W-1:0] : '0;
        n_out.mem_value    = w_s2_mem_wr ? r_s2.sdata : '0;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_out_v    <= 1'b0;
            r_pc       <= '0;
            r_rf_vld   <= '0;
            r_wb_v     <= 1'b0;
            r_mfw_v    <= '0;
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else begin
            // Advance the stage valids
            if (w_s1_free) begin
                r_s1_v <= w_in_acc;
            end
            if (w_s2_free) begin
                r_s2_v <= w_s1_adv;
            end
            if (w_s2_adv) begin
                r_out_v <= 1'b1;
                r_pc    <= n_pc;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end

            // Mark written registers
            if (w_s2_adv && w_s2_rf_we) begin
                r_rf_vld[r_s2.rd] <= 1'b1;
                r_wb_v            <= 1'b1;
            end

            for (int b = 0; b < BANKS; b++) begin
                if (w_bank_we[b]) begin
                    r_mfw_v[b] <= 1'b1;
                end
            end

            // Step the clearing sweep
            if (r_clr_busy) begin
                if (r_clr_row == RW'(ROWS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_row <= r_clr_row + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1 <= i_in_item;
        end
        if (w_s1_adv) begin
            r_s2 <= n_s2;
        end
        if (w_s2_adv) begin
            r_out <= n_out;
        end
        if (w_s2_adv && w_s2_rf_we) begin
            r_wb_idx <= r_s2.rd;
            r_wb_val <= w_s2_result;
        end
        for (int b = 0; b < BANKS; b++) begin
            if (w_bank_we[b]) begin
                r_mfw_row[b]  <= w_bank_waddr[b];
                r_mfw_data[b] <= w_bank_wdata[b];
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule
